[hw/rtl/binary_to_decimal_ascii_top_macros.svh]
// Assertion macros for the binary-to-decimal ASCII printer.
// Used by binary_to_decimal_ascii_top; no other dependencies.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define B2D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define B2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/b2d_pkg.sv]
// Shared types and constants of the binary-to-decimal ASCII printer.
// Used by b2d_ctrl, b2d_datapath, binary_to_decimal_ascii_top, b2d_checker and the testbench.
package b2d_pkg;

  localparam int unsigned VALUE_W       = 20;
  localparam int unsigned CHAR_W        = 6;
  localparam int unsigned STEP_W        = 5;
  localparam int unsigned DIGIT_COUNT_D = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(VALUE_W - 1);

  // Largest value that fits in n decimal digits.
  function automatic logic [63:0] max_decimal(input int unsigned n);
    logic [63:0] lim;
    lim = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      lim = lim * 64'd10;
    end
    return lim - 64'd1;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new value, clear the BCD register
    logic shift;    // one add-3 and shift step
    logic set_ptr;  // point at the leading nonzero digit
    logic emit;     // load the output register with the pointed digit
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ptr_zero; // pointer is at the units digit
  } dp_sts_t;

endpackage

[hw/rtl/b2d_ctrl.sv]
// Sequencer of the binary-to-decimal ASCII printer: conversion steps and emit.
// Depends on b2d_pkg for command and status types.
module b2d_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output b2d_pkg::dp_cmd_t cmd_o,
  input  b2d_pkg::dp_sts_t sts_i
);
  import b2d_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  logic              room;

  assign room        = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: cmd_o.load    = in_valid_i;
      ST_CONV: cmd_o.shift   = 1'b1;
      ST_SCAN: cmd_o.set_ptr = 1'b1;
      ST_EMIT: cmd_o.emit    = room;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // output register: fill on emit, drop on transfer
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            step_q  <= '0;
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_LAST) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: state_q <= ST_EMIT;
        ST_EMIT: begin
          if (room && sts_i.ptr_zero) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/b2d_datapath.sv]
// Datapath of the binary-to-decimal ASCII printer: saturation, double dabble,
// digit pointer and output character register. Depends on b2d_pkg.
module b2d_datapath #(
  parameter int unsigned DIGIT_COUNT = b2d_pkg::DIGIT_COUNT_D
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [b2d_pkg::VALUE_W-1:0]  value_i,
  input  b2d_pkg::dp_cmd_t             cmd_i,
  output b2d_pkg::dp_sts_t             sts_o,
  output logic [b2d_pkg::CHAR_W-1:0]   ascii_char_o,
  output logic                         last_o
);
  import b2d_pkg::*;

  localparam int unsigned BCD_W = 4 * DIGIT_COUNT;
  localparam int unsigned PTR_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [63:0] SAT_LIM = max_decimal(DIGIT_COUNT);

  logic [VALUE_W-1:0] bin_q;
  logic [BCD_W-1:0]   bcd_q;
  logic [PTR_W-1:0]   ptr_q;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;

  logic [VALUE_W-1:0] sat_value;
  logic [BCD_W-1:0]   bcd_adj;
  logic [PTR_W-1:0]   top_idx;
  logic [3:0]         sel_digit;

  // clamp to the largest printable value
  assign sat_value = ({{(64-VALUE_W){1'b0}}, value_i} > SAT_LIM) ?
                     SAT_LIM[VALUE_W-1:0] : value_i;

  always_comb begin
    bcd_adj   = bcd_q;
    top_idx   = '0;
    sel_digit = '0;
    for (int unsigned i = 0; i < DIGIT_COUNT; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
      if (bcd_q[4*i +: 4] != 4'd0) begin
        top_idx = PTR_W'(i);
      end
      if (ptr_q == PTR_W'(i)) begin
        sel_digit = bcd_q[4*i +: 4];
      end
    end
  end

  assign sts_o.ptr_zero = (ptr_q == '0);
  assign ascii_char_o   = char_q;
  assign last_o         = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.set_ptr) begin
      ptr_q <= top_idx;
    end else if (cmd_i.emit && (ptr_q != '0)) begin
      ptr_q <= ptr_q - PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q  <= '0;
      bcd_q  <= '0;
      char_q <= '0;
      last_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        bin_q <= sat_value;
        bcd_q <= '0;
      end else if (cmd_i.shift) begin
        bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
        bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
      end
      if (cmd_i.emit) begin
        char_q <= ASCII_ZERO + {2'b00, sel_digit};
        last_q <= (ptr_q == '0);
      end
    end
  end

endmodule

[hw/rtl/binary_to_decimal_ascii_top.sv]
// Binary-to-decimal ASCII printer: 20 double-dabble steps, then one character
// per cycle while the output is free, from the leading nonzero digit down. The
// one-bit-per-cycle shift loop and the single output register serve one value
// at a time: a new value is taken only after the last character of the previous
// one is emitted. Reset (rst_ni low, asynchronous) returns to idle with the
// output empty.
module binary_to_decimal_ascii_top #(
  parameter int unsigned DIGIT_COUNT = b2d_pkg::DIGIT_COUNT_D
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [19:0] value, [23:20] zero
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [5:0] ascii_char, [7:6] zero
  output logic       m_axis_tlast
);
  import b2d_pkg::*;

  `include "binary_to_decimal_ascii_top_macros.svh"

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [CHAR_W-1:0] ascii_char;

  // Sequencer: accepts a value only when idle, steps the conversion,
  // then hands characters to the output register as it frees up.
  b2d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath: saturate, convert to BCD, walk the digits from the top.
  b2d_datapath #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (s_axis_tdata[VALUE_W-1:0]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .ascii_char_o (ascii_char),
    .last_o       (m_axis_tlast)
  );

  // Pad the 6-bit character to a byte.
  assign m_axis_tdata = {2'b00, ascii_char};

  // A shown character is always a decimal digit.
  `B2D_ASSERT_NOW(a_digit_range, m_axis_tvalid, (m_axis_tdata[7:4] == 4'h3) && (m_axis_tdata[3:0] <= 4'd9), "output character is not a decimal digit")
  // Only the closing character of a run may still wait when a new value comes in.
  `B2D_ASSERT_NOW(a_idle_holds_last, s_axis_tvalid && s_axis_tready, !m_axis_tvalid || m_axis_tlast, "new value accepted in the middle of a character run")
  // Once a value is taken, the block is busy converting it.
  `B2D_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready && !cmd.emit, "not busy right after a value transfer")

endmodule

[dv/b2d_checker.sv]
// Scoreboard for the binary-to-decimal ASCII printer: watches both stream channels,
// predicts the printed characters and compares each output transfer with them.
// Depends on b2d_pkg for widths and the ASCII base code.
module b2d_checker
  import b2d_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [23:0]       s_tdata_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [7:0]        m_tdata_i,
  input  logic              m_tlast_i,
  output int unsigned       mismatch_cnt_o,
  output int unsigned       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    logic              last;
  } char_item_t;

  localparam int unsigned SAT_VALUE = 10 ** DIGIT_COUNT_D - 1;

  char_item_t char_q[$];

  // Saturate, split into decimal digits, drop leading zeros, queue the characters.
  function automatic void push_decimal_chars(input logic [VALUE_W-1:0] value);
    int unsigned v;
    int unsigned digit[DIGIT_COUNT_D];
    int          lead;
    char_item_t  item;
    v = (value > SAT_VALUE) ? SAT_VALUE : int'(value);
    for (int i = 0; i < DIGIT_COUNT_D; i++) begin
      digit[i] = v % 10;
      v = v / 10;
    end
    lead = 0;
    for (int i = DIGIT_COUNT_D - 1; i > 0; i--) begin
      if (lead == 0 && digit[i] != 0) begin
        lead = i;
      end
    end
    for (int i = lead; i >= 0; i--) begin
      item.ascii_char = ASCII_ZERO + CHAR_W'(digit[i]);
      item.last       = (i == 0);
      char_q.push_back(item);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    char_item_t want;
    if (!rst_ni) begin
      char_q.delete();
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (char_q.size() == 0) begin
          if (mismatch_cnt_o < 10) begin
            $display("%0t: unexpected character 0x%02h last %0b", $realtime,
                     m_tdata_i[CHAR_W-1:0], m_tlast_i);
          end
          mismatch_cnt_o <= mismatch_cnt_o + 1;
        end else begin
          want = char_q.pop_front();
          if (m_tdata_i[CHAR_W-1:0] !== want.ascii_char || m_tlast_i !== want.last) begin
            if (mismatch_cnt_o < 10) begin
              $display("%0t: char exp 0x%02h got 0x%02h, last exp %0b got %0b", $realtime,
                       want.ascii_char, m_tdata_i[CHAR_W-1:0], want.last, m_tlast_i);
            end
            mismatch_cnt_o <= mismatch_cnt_o + 1;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        push_decimal_chars(s_tdata_i[VALUE_W-1:0]);
      end
      pending_o <= char_q.size();
    end
  end

endmodule

[dv/binary_to_decimal_ascii_top_tb.sv]
// Testbench top for binary_to_decimal_ascii_top: clock, reset, value stimulus and
// output back-pressure; checking is done by b2d_checker. Depends on b2d_pkg.
module binary_to_decimal_ascii_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import b2d_pkg::*;

  localparam int unsigned PHASE_ITEMS    = 60;
  localparam int unsigned PRESSURE_ITEMS = 10;
  localparam int unsigned TAIL_ITEMS     = 50;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [19:0] value, [23:20] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [5:0] ascii_char, [7:6] zero
  logic        m_axis_tlast;

  int unsigned char_mismatches;
  int unsigned chars_pending;

  // Idling controls: source gaps are used only by the stimulus process, sink
  // stalls and the long hold-off request are picked up by the sink process.
  bit          src_idle_en   = 1'b0;
  logic        sink_stall_en = 1'b0;
  logic        hold_toggle   = 1'b0;
  logic        hold_seen     = 1'b0;
  int unsigned stall_left    = 0;
  int unsigned quiet_cycles  = 0;

  binary_to_decimal_ascii_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  b2d_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .m_tlast_i      (m_axis_tlast),
    .mismatch_cnt_o (char_mismatches),
    .pending_o      (chars_pending)
  );

  // 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Gap length: mostly short, now and then a long one.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 80) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 60);
  endfunction

  // Random value: spread over the full 20-bit field, over each digit count,
  // over the saturating range and over short numbers.
  function automatic logic [VALUE_W-1:0] rand_value();
    int unsigned pick;
    int unsigned ndig;
    int unsigned lo;
    int unsigned hi;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      return VALUE_W'($urandom_range(0, int'(VALUE_MAX)));
    end else if (pick < 70) begin
      ndig = $urandom_range(1, DIGIT_COUNT_D);
      lo   = (ndig == 1) ? 0 : 10 ** (ndig - 1);
      hi   = 10 ** ndig - 1;
      return VALUE_W'($urandom_range(lo, hi));
    end else if (pick < 80) begin
      return VALUE_W'($urandom_range(10 ** DIGIT_COUNT_D, int'(VALUE_MAX)));
    end
    return VALUE_W'($urandom_range(0, 99));
  endfunction

  // Offer one value, with an optional gap in front, and hold it until the
  // transfer. With no gap, tvalid simply stays high for the next value.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = (src_idle_en && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(24 - VALUE_W){1'b0}}, value};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Pause the sender until every predicted character has arrived. The first
  // edge lets the checker count the value that was just transferred.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (chars_pending != 0) @(posedge clk_i);
  endtask

  // Sink side: a long hold-off when requested, random stalls when enabled,
  // otherwise always ready.
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen     <= hold_toggle;
      stall_left    <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_stall_en && $urandom_range(0, 99) < 25) begin
      stall_left    <= idle_len();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [VALUE_W-1:0] directed[$];
    directed = '{20'd0, 20'd1, 20'd9, 20'd10, 20'd99, 20'd100, 20'd999, 20'd1000,
                 20'd9999, 20'd10000, 20'd99999, 20'd100000, 20'd999998, 20'd999999,
                 20'd1000000, VALUE_MAX, 20'h55555, 20'hAAAAA, 20'd123456,
                 20'd500000, 20'd90, 20'd900, 20'd1001, 20'd65535};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed values back to back: field extremes, every digit count,
    // zero and the saturating range.
    foreach (directed[i]) begin
      send_value(directed[i]);
    end
    wait_drained();

    // Random phases with different idling on each side, including one with
    // no idling at all; drain between phases.
    for (int phase = 0; phase < 4; phase++) begin
      src_idle_en    = (phase == 0 || phase == 1);
      sink_stall_en <= (phase == 0 || phase == 2);
      repeat (PHASE_ITEMS) send_value(rand_value());
      wait_drained();
    end

    // Hold the sink off for a long stretch while values keep coming, so the
    // block fills up and stalls its input.
    src_idle_en  = 1'b0;
    hold_toggle <= ~hold_toggle;
    repeat (PRESSURE_ITEMS) send_value(rand_value());
    wait_drained();

    src_idle_en    = 1'b1;
    sink_stall_en <= 1'b1;
    repeat (TAIL_ITEMS) send_value(rand_value());
    wait_drained();

    // Let any stray character show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (char_mismatches == 0 && chars_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/b2d_pkg.sv
hw/rtl/b2d_ctrl.sv
hw/rtl/b2d_datapath.sv
hw/rtl/binary_to_decimal_ascii_top.sv
dv/b2d_checker.sv
dv/binary_to_decimal_ascii_top_tb.sv
